// ----- design/cwb_pkg.sv -----
package cwb_pkg;
  localparam int unsigned CFG_WIDTH = 6;
  localparam int unsigned CFG_INDEX_WIDTH = 1;
  localparam int unsigned WEIGHT_WIDTH = 16;
  localparam int unsigned ACC_WIDTH = 40;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_NUM_ANTENNAS = 1'b0,
    REG_NUM_BEAMS    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_WEIGHT = 1'b0,
    CMD_SAMPLE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  typedef struct packed {
    logic mac;
    logic clear;
    logic shift;
  } cell_ctrl_t;
endpackage

// ----- design/cwb_if.sv -----
interface cwb_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic valid;
  logic ready;
  logic command;
  logic [1:0] channel;
  logic [4:0] beam;
  logic [4:0] antenna;
  logic signed [15:0] weight_re;
  logic signed [15:0] weight_im;
  logic signed [SAMPLE_WIDTH-1:0] sample_re;
  logic signed [SAMPLE_WIDTH-1:0] sample_im;
  modport source (output valid, command, channel, beam, antenna, weight_re, weight_im,
                  sample_re, sample_im, input ready);
  modport sink (input valid, command, channel, beam, antenna, weight_re, weight_im,
                sample_re, sample_im, output ready);
endinterface

interface cwb_out_if;
  logic valid;
  logic ready;
  logic [4:0] out_beam;
  logic [1:0] out_channel;
  logic signed [39:0] beam_re;
  logic signed [39:0] beam_im;
  logic last;
  modport source (output valid, out_beam, out_channel, beam_re, beam_im, last, input ready);
  modport sink (input valid, out_beam, out_channel, beam_re, beam_im, last, output ready);
endinterface

// ----- design/cwb_cell.sv -----
module cwb_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CH_BITS = 2,
  parameter int ANT_BITS = 5
) (
  input  logic clk,
  input  cwb_pkg::cell_ctrl_t ctrl,
  input  logic weight_we,
  input  logic [CH_BITS+ANT_BITS-1:0] weight_waddr,
  input  logic signed [cwb_pkg::WEIGHT_WIDTH-1:0] weight_wre,
  input  logic signed [cwb_pkg::WEIGHT_WIDTH-1:0] weight_wim,
  input  logic [CH_BITS+ANT_BITS-1:0] weight_raddr,
  input  logic weight_rzero,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
  input  logic signed [cwb_pkg::ACC_WIDTH-1:0] chain_re_in,
  input  logic signed [cwb_pkg::ACC_WIDTH-1:0] chain_im_in,
  output logic signed [cwb_pkg::ACC_WIDTH-1:0] acc_re,
  output logic signed [cwb_pkg::ACC_WIDTH-1:0] acc_im
);
  localparam int DEPTH = 2 ** (CH_BITS + ANT_BITS);
  localparam int PW = SAMPLE_WIDTH + cwb_pkg::WEIGHT_WIDTH;

  logic signed [cwb_pkg::WEIGHT_WIDTH-1:0] mem_re [DEPTH];
  logic signed [cwb_pkg::WEIGHT_WIDTH-1:0] mem_im [DEPTH];
  logic signed [cwb_pkg::WEIGHT_WIDTH-1:0] w_re;
  logic signed [cwb_pkg::WEIGHT_WIDTH-1:0] w_im;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [cwb_pkg::ACC_WIDTH-1:0] acc_re_next, acc_im_next;

  always_ff @(posedge clk) begin
    if (weight_we) begin
      mem_re[weight_waddr] <= weight_wre;
      mem_im[weight_waddr] <= weight_wim;
    end
    w_re <= weight_rzero ? '0 : mem_re[weight_raddr];
    w_im <= weight_rzero ? '0 : mem_im[weight_raddr];
  end

  always_ff @(posedge clk) begin
    p_rr <= PW'(sample_re) * PW'(w_re);
    p_ii <= PW'(sample_im) * PW'(w_im);
    p_ri <= PW'(sample_re) * PW'(w_im);
    p_ir <= PW'(sample_im) * PW'(w_re);
  end

  always_comb begin
    acc_re_next = acc_re;
    acc_im_next = acc_im;
    if (ctrl.shift) begin
      acc_re_next = chain_re_in;
      acc_im_next = chain_im_in;
    end else if (ctrl.clear) begin
      acc_re_next = '0;
      acc_im_next = '0;
    end else if (ctrl.mac) begin
      acc_re_next = acc_re + cwb_pkg::ACC_WIDTH'(p_rr) - cwb_pkg::ACC_WIDTH'(p_ii);
      acc_im_next = acc_im + cwb_pkg::ACC_WIDTH'(p_ri) + cwb_pkg::ACC_WIDTH'(p_ir);
    end
  end

  always_ff @(posedge clk) begin
    acc_re <= acc_re_next;
    acc_im <= acc_im_next;
  end
endmodule

// ----- design/complex_weight_beamformer.sv -----
// Narrowband beamformer built as a row of one cell per beam. Each cell holds its beam's
// weights for every channel and antenna in a local memory and its own complex accumulator,
// and performs one complex multiply-accumulate per antenna sample. The block takes a new
// weight write or antenna sample every cycle in which it is ready to take input. A sample
// passes a 3-stage pipeline (weight memory read, multiplier register, accumulate), so
// after the final antenna sample input is held off while it drains. Emission then shifts
// the accumulators along the row toward the output, one beam per cycle in which the
// output is ready. All MAX_BEAMS accumulators shift out, so the row ends cleared, but only
// the first num_beams (clamped to 1..MAX_BEAMS) are offered as transactions. Input is
// taken again only after all MAX_BEAMS have shifted out. Accumulators reset to zero
// with a clearing pass after reset, during which input is held off.
module complex_weight_beamformer #(
  parameter int MAX_ANTENNAS = 32,
  parameter int MAX_BEAMS = 32,
  parameter int MAX_CHANNELS = 4,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  cwb_in_if.sink in_ch,
  cwb_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [cwb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [cwb_pkg::CFG_WIDTH-1:0] cfg_data
);
  localparam int CH_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ANT_BITS = (MAX_ANTENNAS > 1) ? $clog2(MAX_ANTENNAS) : 1;
  localparam int BEAM_BITS = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
  localparam int CNT_BITS = $clog2(MAX_ANTENNAS + 1);
  localparam int BC_BITS = $clog2(MAX_BEAMS + 1);
  localparam int AW = cwb_pkg::ACC_WIDTH;

  logic [cwb_pkg::CFG_WIDTH-1:0] num_antennas, num_beams;
  logic [CNT_BITS-1:0] nants;
  logic [BC_BITS-1:0] nbeams;
  cwb_pkg::state_t state;
  logic [CNT_BITS-1:0] antenna_count;
  logic [1:0] pipe_valid, pipe_last;
  logic [BC_BITS-1:0] emit_count, clear_count;
  logic [1:0] out_channel_r, ch_d1, ch_d2;
  logic signed [SAMPLE_WIDTH-1:0] s_re_d, s_im_d;
  logic accept, is_sample, final_sample;
  cwb_pkg::cell_ctrl_t ctrl;
  logic [CH_BITS+ANT_BITS-1:0] waddr, raddr;
  logic rzero;
  logic signed [AW-1:0] chain_re [MAX_BEAMS+1];
  logic signed [AW-1:0] chain_im [MAX_BEAMS+1];
  logic [BEAM_BITS-1:0] beam_idx;

  always_comb begin
    if (num_antennas == '0) nants = CNT_BITS'(1);
    else if (32'(num_antennas) > MAX_ANTENNAS) nants = CNT_BITS'(MAX_ANTENNAS);
    else nants = CNT_BITS'(num_antennas);
    if (num_beams == '0) nbeams = BC_BITS'(1);
    else if (32'(num_beams) > MAX_BEAMS) nbeams = BC_BITS'(MAX_BEAMS);
    else nbeams = BC_BITS'(num_beams);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_antennas <= cwb_pkg::CFG_WIDTH'(32);
      num_beams <= cwb_pkg::CFG_WIDTH'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        cwb_pkg::REG_NUM_ANTENNAS: num_antennas <= cfg_data;
        cwb_pkg::REG_NUM_BEAMS: num_beams <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state == cwb_pkg::ST_RUN) && (clear_count == '0) && !pipe_last[0]
                       && !pipe_last[1];
  assign accept = in_ch.valid && in_ch.ready;
  assign is_sample = accept && (in_ch.command == cwb_pkg::CMD_SAMPLE);
  assign final_sample = is_sample && (antenna_count + CNT_BITS'(1) >= nants);

  assign waddr = {CH_BITS'(in_ch.channel), ANT_BITS'(in_ch.antenna)};
  assign raddr = {CH_BITS'(in_ch.channel), ANT_BITS'(antenna_count)};
  assign rzero = (32'(in_ch.channel) >= MAX_CHANNELS) || (32'(antenna_count) >= MAX_ANTENNAS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cwb_pkg::ST_RUN;
      antenna_count <= '0;
      pipe_valid <= '0;
      pipe_last <= '0;
      emit_count <= '0;
      clear_count <= BC_BITS'(MAX_BEAMS);
    end else begin
      pipe_valid <= {pipe_valid[0], is_sample};
      pipe_last <= {pipe_last[0], final_sample};
      if (clear_count != '0) clear_count <= clear_count - BC_BITS'(1);
      if (is_sample) antenna_count <= final_sample ? '0 : antenna_count + CNT_BITS'(1);
      case (state)
        cwb_pkg::ST_RUN: begin
          if (pipe_last[1]) begin
            state <= cwb_pkg::ST_EMIT;
            emit_count <= '0;
          end
        end
        cwb_pkg::ST_EMIT: begin
          if (out_ch.ready) begin
            if (emit_count + BC_BITS'(1) >= BC_BITS'(MAX_BEAMS)) state <= cwb_pkg::ST_RUN;
            emit_count <= emit_count + BC_BITS'(1);
          end
        end
        default: state <= cwb_pkg::ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s_re_d <= in_ch.sample_re;
    s_im_d <= in_ch.sample_im;
    ch_d1 <= in_ch.channel;
    ch_d2 <= ch_d1;
    if (pipe_last[1]) out_channel_r <= ch_d2;
  end

  always_comb begin
    ctrl.mac = pipe_valid[1];
    ctrl.clear = (clear_count != '0);
    ctrl.shift = (state == cwb_pkg::ST_EMIT) && out_ch.ready;
  end

  assign chain_re[MAX_BEAMS] = '0;
  assign chain_im[MAX_BEAMS] = '0;

  for (genvar b = 0; b < MAX_BEAMS; b++) begin : g_cell
    cwb_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CH_BITS(CH_BITS), .ANT_BITS(ANT_BITS)) u_cell (
      .clk(clk),
      .ctrl(ctrl),
      .weight_we(accept && (in_ch.command == cwb_pkg::CMD_WEIGHT)
                 && (32'(in_ch.beam) == b) && (32'(in_ch.channel) < MAX_CHANNELS)
                 && (32'(in_ch.antenna) < MAX_ANTENNAS)),
      .weight_waddr(waddr),
      .weight_wre(in_ch.weight_re),
      .weight_wim(in_ch.weight_im),
      .weight_raddr(raddr),
      .weight_rzero(rzero),
      .sample_re(s_re_d),
      .sample_im(s_im_d),
      .chain_re_in(chain_re[b+1]),
      .chain_im_in(chain_im[b+1]),
      .acc_re(chain_re[b]),
      .acc_im(chain_im[b])
    );
  end

  assign beam_idx = BEAM_BITS'(emit_count);
  assign out_ch.valid = (state == cwb_pkg::ST_EMIT) && (emit_count < nbeams);
  assign out_ch.out_beam = 5'(beam_idx);
  assign out_ch.out_channel = out_channel_r;
  assign out_ch.beam_re = chain_re[0];
  assign out_ch.beam_im = chain_im[0];
  assign out_ch.last = (emit_count + BC_BITS'(1) == nbeams);

`ifndef SYNTHESIS
  a_no_accept_emit: assert property (@(posedge clk) disable iff (rst)
    (state == cwb_pkg::ST_EMIT) |-> !in_ch.ready) else $error("accept during emission");
  a_emit_after_final: assert property (@(posedge clk) disable iff (rst)
    final_sample |-> ##3 (state == cwb_pkg::ST_EMIT))
    else $error("emission not started");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(antenna_count) < MAX_ANTENNAS) else $error("antenna count overrun");
  a_mac_idle_emit: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift |-> !ctrl.mac) else $error("mac during shift");
`endif
endmodule
